FILE: rtl/dtt_pkg.sv
// Shared types and constants for the temperature text to code converter.
`default_nettype none
package dtt_pkg;

	typedef struct packed {
		logic [7:0] character;
		logic       is_last;
		logic       target;
	} char_word_t;

	typedef struct packed {
		logic [15:0] temp_code;
		logic        target_out;
		logic        parse_error;
	} code_word_t;

	typedef enum logic [2:0] {
		PH_START,
		PH_INT,
		PH_DOT,
		PH_FRAC,
		PH_IGNORE,
		PH_ERROR
	} phase_t;

	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_PLUS  = 8'd43;
	localparam logic [7:0] CHAR_DOT   = 8'd46;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;
	localparam logic [7:0] CHAR_NINE  = 8'd57;

	localparam logic [1:0] FRAC_DIGITS = 2'd2;

	localparam logic [6:0] FRAC_QUARTER       = 7'd25;
	localparam logic [6:0] FRAC_HALF          = 7'd50;
	localparam logic [6:0] FRAC_THREE_QUARTER = 7'd75;

	localparam logic [15:0] CODE_QUARTER       = 16'h0020;
	localparam logic [15:0] CODE_HALF          = 16'h0040;
	localparam logic [15:0] CODE_THREE_QUARTER = 16'h0060;

endpackage
`default_nettype wire

FILE: rtl/dtt_in_stage.sv
// Input register stage that holds one character word until the parser takes it.
`default_nettype none
module dtt_in_stage (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               char_valid,
	output logic                    char_ready,
	input  wire dtt_pkg::char_word_t char_word,
	input  wire logic               out_free,
	output logic                    advance,
	output dtt_pkg::char_word_t     word_s1
);

	logic valid_s1;

	// A closing word needs room in the result register; other words always move on.
	assign advance    = valid_s1 && (!word_s1.is_last || out_free);
	assign char_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_ready) begin
			valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			word_s1 <= char_word;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/dtt_parser.sv
// Text parser state machine and threshold code computation for one character word.
`default_nettype none
module dtt_parser #(
	parameter int INT_DIGITS = 3
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire dtt_pkg::char_word_t word,
	output dtt_pkg::code_word_t      result
);

	localparam logic [1:0] INT_LIMIT = 2'(INT_DIGITS);

	dtt_pkg::phase_t phase_q, phase_d;
	logic            negative_q, negative_d;
	logic [9:0]      int_val_q, int_val_d;
	logic [1:0]      int_cnt_q, int_cnt_d;
	logic [6:0]      frac_val_q, frac_val_d;
	logic [1:0]      frac_cnt_q, frac_cnt_d;

	logic       is_digit;
	logic [3:0] digit;
	logic       err;
	logic [15:0] code_abs;

	assign is_digit = (word.character >= dtt_pkg::CHAR_ZERO) &&
	                  (word.character <= dtt_pkg::CHAR_NINE);
	assign digit    = word.character[3:0];

	always_comb begin
		phase_d    = phase_q;
		negative_d = negative_q;
		int_val_d  = int_val_q;
		int_cnt_d  = int_cnt_q;
		frac_val_d = frac_val_q;
		frac_cnt_d = frac_cnt_q;
		unique case (phase_q)
			dtt_pkg::PH_START: begin
				if (word.character == dtt_pkg::CHAR_MINUS) begin
					negative_d = 1'b1;
					phase_d    = dtt_pkg::PH_INT;
				end else if (word.character == dtt_pkg::CHAR_PLUS) begin
					phase_d = dtt_pkg::PH_INT;
				end else if (is_digit) begin
					int_val_d = {6'd0, digit};
					int_cnt_d = 2'd1;
					phase_d   = dtt_pkg::PH_INT;
				end else begin
					phase_d = dtt_pkg::PH_ERROR;
				end
			end
			dtt_pkg::PH_INT: begin
				if (is_digit) begin
					if (int_cnt_q >= INT_LIMIT) begin
						phase_d = dtt_pkg::PH_ERROR;
					end else begin
						int_val_d = {int_val_q[6:0], 3'd0} + {int_val_q[8:0], 1'b0}
						            + {6'd0, digit};
						int_cnt_d = int_cnt_q + 2'd1;
					end
				end else if (int_cnt_q == 2'd0) begin
					phase_d = dtt_pkg::PH_ERROR;
				end else if (word.character == dtt_pkg::CHAR_DOT) begin
					phase_d = dtt_pkg::PH_DOT;
				end else begin
					phase_d = dtt_pkg::PH_IGNORE;
				end
			end
			dtt_pkg::PH_DOT: begin
				if (is_digit) begin
					frac_val_d = {3'd0, digit};
					frac_cnt_d = 2'd1;
					phase_d    = dtt_pkg::PH_FRAC;
				end else begin
					phase_d = dtt_pkg::PH_IGNORE;
				end
			end
			dtt_pkg::PH_FRAC: begin
				if (is_digit) begin
					if (frac_cnt_q >= dtt_pkg::FRAC_DIGITS) begin
						phase_d = dtt_pkg::PH_ERROR;
					end else begin
						frac_val_d = {frac_val_q[3:0], 3'd0} + {frac_val_q[5:0], 1'b0}
						             + {3'd0, digit};
						frac_cnt_d = frac_cnt_q + 2'd1;
					end
				end else begin
					phase_d = dtt_pkg::PH_IGNORE;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	always_comb begin
		err = (phase_d == dtt_pkg::PH_ERROR) || (phase_d == dtt_pkg::PH_START) ||
		      ((phase_d == dtt_pkg::PH_INT) && (int_cnt_d == 2'd0));
		code_abs = {int_val_d[8:0], 7'd0};
		case (frac_val_d)
			dtt_pkg::FRAC_QUARTER:       code_abs = code_abs + dtt_pkg::CODE_QUARTER;
			dtt_pkg::FRAC_HALF:          code_abs = code_abs + dtt_pkg::CODE_HALF;
			dtt_pkg::FRAC_THREE_QUARTER: code_abs = code_abs + dtt_pkg::CODE_THREE_QUARTER;
			default:                     code_abs = code_abs;
		endcase
		result.target_out  = word.target;
		result.parse_error = err;
		if (err) begin
			result.temp_code = 16'd0;
		end else if (negative_d) begin
			result.temp_code = ~code_abs + 16'd1;
		end else begin
			result.temp_code = code_abs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= dtt_pkg::PH_START;
			negative_q <= 1'b0;
			int_val_q  <= 10'd0;
			int_cnt_q  <= 2'd0;
			frac_val_q <= 7'd0;
			frac_cnt_q <= 2'd0;
		end else if (take) begin
			if (word.is_last) begin
				phase_q    <= dtt_pkg::PH_START;
				negative_q <= 1'b0;
				int_val_q  <= 10'd0;
				int_cnt_q  <= 2'd0;
				frac_val_q <= 7'd0;
				frac_cnt_q <= 2'd0;
			end else begin
				phase_q    <= phase_d;
				negative_q <= negative_d;
				int_val_q  <= int_val_d;
				int_cnt_q  <= int_cnt_d;
				frac_val_q <= frac_val_d;
				frac_cnt_q <= frac_cnt_d;
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/dtt_out_reg.sv
// Result register that holds one code word until the consumer takes it.
`default_nettype none
module dtt_out_reg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                load,
	input  wire dtt_pkg::code_word_t result,
	output logic                     out_free,
	output logic                     code_valid,
	input  wire logic                code_ready,
	output dtt_pkg::code_word_t      code_word
);

	logic valid_q;

	assign code_valid = valid_q;
	assign out_free   = !valid_q || code_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (code_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			code_word <= result;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/decimal_text_to_temp_code.sv
// Top level of the temperature text to threshold code converter.
// A closing word is held in the input stage, then its result word in the result register.
// Throughput: one character word per cycle from the parser state update, unless stalled.
// A waiting result stalls the next closing character and every character behind it.
// Reset: arst_n clears the parser to its start state and empties both registers.
`default_nettype none
module decimal_text_to_temp_code #(
	parameter int INT_DIGITS = 3
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                char_valid,
	output logic                     char_ready,
	input  wire dtt_pkg::char_word_t char_word,
	output logic                     code_valid,
	input  wire logic                code_ready,
	output dtt_pkg::code_word_t      code_word
);

	dtt_pkg::char_word_t word_s1;
	dtt_pkg::code_word_t result;
	logic                advance;
	logic                out_free;

	dtt_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_word  (char_word),
		.out_free   (out_free),
		.advance    (advance),
		.word_s1    (word_s1)
	);

	dtt_parser #(
		.INT_DIGITS (INT_DIGITS)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (advance),
		.word   (word_s1),
		.result (result)
	);

	dtt_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (advance && word_s1.is_last),
		.result     (result),
		.out_free   (out_free),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code_word  (code_word)
	);

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the temperature text to code converter: random and directed texts against a predictor.
module tb_top;

	localparam int INT_DIGITS = 3;
	localparam int DRAIN_CYCLES = 10;
	localparam int TIMEOUT_CYCLES = 200000;

	typedef logic [7:0] byte_q_t[$];

	typedef struct {
		dtt_pkg::phase_t phase;
		logic            negative;
		logic [9:0]      int_val;
		logic [1:0]      int_cnt;
		logic [6:0]      frac_val;
		logic [1:0]      frac_cnt;
	} parser_state_t;

	localparam parser_state_t PARSER_IDLE =
		'{dtt_pkg::PH_START, 1'b0, 10'd0, 2'd0, 7'd0, 2'd0};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                char_valid;
	logic                char_ready;
	dtt_pkg::char_word_t char_word;
	logic                code_valid;
	logic                code_ready = 1'b0;
	dtt_pkg::code_word_t code_word;

	parser_state_t       parser = PARSER_IDLE;
	dtt_pkg::code_word_t pending_codes[$];
	int                  failures = 0;
	int                  counted_items = 0;
	bit                  tx_idle = 1'b0;
	bit                  rx_idle = 1'b0;
	int                  rx_stall = 0;

	decimal_text_to_temp_code #(.INT_DIGITS(INT_DIGITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_word(char_word),
		.code_valid(code_valid),
		.code_ready(code_ready),
		.code_word(code_word)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic is_numeral(input logic [7:0] c);
		return c >= dtt_pkg::CHAR_ZERO && c <= dtt_pkg::CHAR_NINE;
	endfunction

	function automatic logic [7:0] random_digit();
		return dtt_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
	endfunction

	function automatic byte_q_t text_bytes(input string s);
		byte_q_t q;
		for (int i = 0; i < s.len(); i++) begin
			q.push_back(s[i]);
		end
		return q;
	endfunction

	task automatic parse_char(input dtt_pkg::char_word_t w);
		logic [7:0]  c;
		logic [15:0] code;
		logic        err;
		c = w.character;
		case (parser.phase)
			dtt_pkg::PH_START: begin
				if (c == dtt_pkg::CHAR_MINUS) begin
					parser.negative = 1'b1;
					parser.phase = dtt_pkg::PH_INT;
				end else if (c == dtt_pkg::CHAR_PLUS) begin
					parser.phase = dtt_pkg::PH_INT;
				end else if (is_numeral(c)) begin
					parser.int_val = 10'(c - dtt_pkg::CHAR_ZERO);
					parser.int_cnt = 2'd1;
					parser.phase = dtt_pkg::PH_INT;
				end else begin
					parser.phase = dtt_pkg::PH_ERROR;
				end
			end
			dtt_pkg::PH_INT: begin
				if (is_numeral(c)) begin
					if (parser.int_cnt >= INT_DIGITS) begin
						parser.phase = dtt_pkg::PH_ERROR;
					end else begin
						parser.int_val = 10'(parser.int_val * 10 + (c - dtt_pkg::CHAR_ZERO));
						parser.int_cnt++;
					end
				end else if (parser.int_cnt == 2'd0) begin
					parser.phase = dtt_pkg::PH_ERROR;
				end else if (c == dtt_pkg::CHAR_DOT) begin
					parser.phase = dtt_pkg::PH_DOT;
				end else begin
					parser.phase = dtt_pkg::PH_IGNORE;
				end
			end
			dtt_pkg::PH_DOT: begin
				if (is_numeral(c)) begin
					parser.frac_val = 7'(c - dtt_pkg::CHAR_ZERO);
					parser.frac_cnt = 2'd1;
					parser.phase = dtt_pkg::PH_FRAC;
				end else begin
					parser.phase = dtt_pkg::PH_IGNORE;
				end
			end
			dtt_pkg::PH_FRAC: begin
				if (is_numeral(c)) begin
					if (parser.frac_cnt >= dtt_pkg::FRAC_DIGITS) begin
						parser.phase = dtt_pkg::PH_ERROR;
					end else begin
						parser.frac_val = 7'(parser.frac_val * 10 + (c - dtt_pkg::CHAR_ZERO));
						parser.frac_cnt++;
					end
				end else begin
					parser.phase = dtt_pkg::PH_IGNORE;
				end
			end
			default: begin
			end
		endcase
		if (w.is_last) begin
			err = parser.phase == dtt_pkg::PH_ERROR || parser.phase == dtt_pkg::PH_START ||
				(parser.phase == dtt_pkg::PH_INT && parser.int_cnt == 2'd0);
			code = 16'd0;
			if (!err) begin
				code = 16'(parser.int_val) << 7;
				case (parser.frac_val)
					dtt_pkg::FRAC_QUARTER:       code += dtt_pkg::CODE_QUARTER;
					dtt_pkg::FRAC_HALF:          code += dtt_pkg::CODE_HALF;
					dtt_pkg::FRAC_THREE_QUARTER: code += dtt_pkg::CODE_THREE_QUARTER;
					default: begin
					end
				endcase
				if (parser.negative) begin
					code = -code;
				end
			end
			pending_codes.push_back('{temp_code: code, target_out: w.target, parse_error: err});
			parser = PARSER_IDLE;
		end
	endtask

	task automatic send_char(input logic [7:0] c, input logic last, input logic tgt);
		dtt_pkg::char_word_t w;
		w = '{character: c, is_last: last, target: tgt};
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		char_valid <= 1'b1;
		char_word <= w;
		do @(posedge clk); while (!char_ready);
		if (!(parser.phase inside {dtt_pkg::PH_IGNORE, dtt_pkg::PH_ERROR}) || last) begin
			counted_items++;
		end
		parse_char(w);
	endtask

	task automatic send_bytes(input byte_q_t text, input logic tgt);
		foreach (text[i]) begin
			send_char(text[i], i == text.size() - 1, tgt);
		end
	endtask

	task automatic send_text(input string s, input logic tgt);
		send_bytes(text_bytes(s), tgt);
	endtask

	task automatic test_directed_cases();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_text("-999.75", 1'b0);
		send_text("+1.50", 1'b1);
		send_char(8'hFF, 1'b1, 1'b0);
		send_text("1234", 1'b1);
		send_text("0.234", 1'b0);
		send_text("-", 1'b1);
		send_char("7", 1'b0, 1'b0);
		send_char(dtt_pkg::CHAR_DOT, 1'b0, 1'b0);
		send_char(8'h00, 1'b1, 1'b1);
	endtask

	task automatic test_valid_texts(input int goal, input bit allow_idle);
		byte_q_t text;
		int      quarter;
		while (counted_items < goal) begin
			text = {};
			tx_idle = allow_idle && $urandom_range(0, 3) != 0;
			rx_idle = allow_idle && $urandom_range(0, 3) != 0;
			case ($urandom_range(0, 2))
				1: text.push_back(dtt_pkg::CHAR_MINUS);
				2: text.push_back(dtt_pkg::CHAR_PLUS);
				default: begin
				end
			endcase
			repeat ($urandom_range(1, INT_DIGITS)) text.push_back(random_digit());
			case ($urandom_range(0, 5))
				0: begin
				end
				1: text.push_back(dtt_pkg::CHAR_DOT);
				2: begin
					text.push_back(dtt_pkg::CHAR_DOT);
					text.push_back(random_digit());
				end
				3: begin
					text.push_back(dtt_pkg::CHAR_DOT);
					text.push_back(random_digit());
					text.push_back(random_digit());
				end
				default: begin
					quarter = $urandom_range(1, 3) * 25;
					text.push_back(dtt_pkg::CHAR_DOT);
					text.push_back(dtt_pkg::CHAR_ZERO + 8'(quarter / 10));
					text.push_back(dtt_pkg::CHAR_ZERO + 8'(quarter % 10));
				end
			endcase
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
			end
			send_bytes(text, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_malformed_texts(input int goal);
		byte_q_t text;
		while (counted_items < goal) begin
			text = {};
			tx_idle = $urandom_range(0, 3) != 0;
			rx_idle = $urandom_range(0, 3) != 0;
			repeat ($urandom_range(1, 6)) begin
				case ($urandom_range(0, 4))
					0: text.push_back(random_digit());
					1: text.push_back(dtt_pkg::CHAR_DOT);
					2: text.push_back($urandom_range(0, 1) ? dtt_pkg::CHAR_MINUS
						: dtt_pkg::CHAR_PLUS);
					default: text.push_back(8'($urandom_range(0, 255)));
				endcase
			end
			send_bytes(text, 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic test_drain_pause();
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		send_text("12.5", 1'b0);
		char_valid <= 1'b0;
		while (pending_codes.size() != 0) @(posedge clk);
		send_text("-0.25", 1'b1);
	endtask

	always @(posedge clk) begin
		if (!arst_n || !rx_idle) begin
			code_ready <= 1'b1;
		end else if (rx_stall > 0) begin
			rx_stall--;
			code_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			rx_stall = $urandom_range(0, 6);
			code_ready <= 1'b0;
		end else begin
			code_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		dtt_pkg::code_word_t want;
		if (arst_n && code_valid && code_ready) begin
			if (pending_codes.size() == 0) begin
				$error("result word with no expectation: %h", code_word);
				failures++;
			end else begin
				want = pending_codes.pop_front();
				if (code_word.temp_code !== want.temp_code) begin
					$error("temp_code: expected %h, actual %h", want.temp_code, code_word.temp_code);
					failures++;
				end
				if (code_word.target_out !== want.target_out) begin
					$error("target_out: expected %b, actual %b", want.target_out,
						code_word.target_out);
					failures++;
				end
				if (code_word.parse_error !== want.parse_error) begin
					$error("parse_error: expected %b, actual %b", want.parse_error,
						code_word.parse_error);
					failures++;
				end
			end
		end
	end

	initial begin
		#(TIMEOUT_CYCLES * 20);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		char_valid = 1'b0;
		char_word = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_valid_texts(450, 1'b1);
		test_drain_pause();
		test_malformed_texts(700);
		test_valid_texts(800, 1'b1);
		test_valid_texts(900, 1'b0);
		char_valid <= 1'b0;
		while (pending_codes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

FILE: sim.f
rtl/dtt_pkg.sv
rtl/dtt_in_stage.sv
rtl/dtt_parser.sv
rtl/dtt_out_reg.sv
rtl/decimal_text_to_temp_code.sv
test/tb_top.sv
